// File: design/mhdf_pkg.sv
// ----------------------------------------------------------------------------
// mhdf_pkg
// Shared types, constants and the hash step for the message hash duplicate
// filter.
// ----------------------------------------------------------------------------
package mhdf_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  // Probe token that walks the pool chain one cell per cycle
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [HASH_W-1:0] hash;
  } probe_t;

  // One djb2-xor step: h * 33 xor byte, modulo 2^32
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] mul;
    mul = (h << HASH_SHIFT) + h;
    return mul ^ {{(HASH_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

// File: design/message_hash_dedup_filter_unit.sv
// ----------------------------------------------------------------------------
// message_hash_dedup_filter_unit
// Running djb2-xor hash over message bytes with a duplicate check against a
// pool of recent message hashes.
// ----------------------------------------------------------------------------
// Byte words are taken one per cycle and fold into the running hash at once.
// A word marked end_of_message launches the final hash into a chain of
// POOL_DEPTH cells, one pool entry per cell; the probe moves one cell per
// cycle, and the result is registered from the probe that leaves the last
// cell. A unique hash is then pushed in at the head of the chain and the
// oldest entry drops off the far end. While a probe is in flight or a result
// waits on the output, further end words are stalled; plain byte words still
// flow. The pool is cleared to zero by reset and zero never matches.
module message_hash_dedup_filter_unit #(
  parameter int POOL_DEPTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mhdf_pkg::BYTE_W-1:0]   msg_byte,
  input  logic                          no_byte,
  input  logic                          end_of_message,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_duplicate,
  output logic [mhdf_pkg::HASH_W-1:0]   message_hash
);
  import mhdf_pkg::*;

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [HASH_W-1:0] hash_folded;
  logic [HASH_W-1:0] fin_hash;
  logic              busy;
  logic              in_accept;
  logic              end_accept;
  probe_t            launch;
  probe_t            chain [0:POOL_DEPTH];
  logic [HASH_W-1:0] entries [0:POOL_DEPTH];
  probe_t            exit_probe;
  logic              shift_en;

  assign in_stall   = end_of_message & (busy | out_valid);
  assign in_accept  = in_valid & ~in_stall;
  assign end_accept = in_accept & end_of_message;

  assign hash_folded = no_byte ? running_hash : hash_step(running_hash, msg_byte);
  assign fin_hash    = (hash_folded == '0) ? {{(HASH_W-1){1'b0}}, 1'b1} : hash_folded;

  always_comb begin
    running_hash_next = running_hash;
    if (in_accept) begin
      running_hash_next = end_of_message ? HASH_SEED : hash_folded;
    end
  end

  assign chain[0]   = launch;
  assign exit_probe = chain[POOL_DEPTH];
  assign shift_en   = exit_probe.valid & ~exit_probe.hit;
  assign entries[0] = exit_probe.hash;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    mhdf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_in (chain[i]),
      .probe_out(chain[i+1]),
      .shift_en (shift_en),
      .entry_in (entries[i]),
      .entry    (entries[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
      launch.valid <= 1'b0;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      running_hash <= running_hash_next;
      launch.valid <= end_accept;
      // hold busy from launch until the probe leaves the last cell
      if (end_accept) begin
        busy <= 1'b1;
      end else if (exit_probe.valid) begin
        busy <= 1'b0;
      end
      if (exit_probe.valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    launch.hit <= 1'b0;
    if (end_accept) begin
      launch.hash <= fin_hash;
    end
    if (exit_probe.valid) begin
      is_duplicate <= exit_probe.hit;
      message_hash <= exit_probe.hash;
    end
  end

`ifndef NO_ASSERTIONS
  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (message_hash != '0))
    else $error("result hash is zero");

  a_end_when_idle: assert property (@(posedge clk) disable iff (rst)
    end_accept |-> (!busy && !out_valid))
    else $error("end word taken while a probe or result is pending");

  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    end_accept |=> busy)
    else $error("busy not raised after an end word");

  a_exit_while_busy: assert property (@(posedge clk) disable iff (rst)
    exit_probe.valid |-> busy)
    else $error("probe left the chain while not busy");

  a_insert_head: assert property (@(posedge clk) disable iff (rst)
    shift_en |=> (entries[1] != '0))
    else $error("inserted entry at chain head is zero");
`endif

endmodule

// File: design/mhdf_cell.sv
// ----------------------------------------------------------------------------
// mhdf_cell
// One pool entry. Compares the passing probe against its entry and hands the
// probe on; shifts in its neighbor's entry on an insert.
// ----------------------------------------------------------------------------
module mhdf_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mhdf_pkg::probe_t              probe_in,
  output mhdf_pkg::probe_t              probe_out,
  input  logic                          shift_en,
  input  logic [mhdf_pkg::HASH_W-1:0]   entry_in,
  output logic [mhdf_pkg::HASH_W-1:0]   entry
);
  import mhdf_pkg::*;

  probe_t probe_next;

  always_comb begin
    probe_next     = probe_in;
    probe_next.hit = probe_in.hit | (probe_in.valid && (probe_in.hash == entry));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
      entry           <= '0;
    end else begin
      probe_out.valid <= probe_next.valid;
      if (shift_en) begin
        entry <= entry_in;
      end
    end
    probe_out.hit  <= probe_next.hit;
    probe_out.hash <= probe_next.hash;
  end

endmodule
